// ===== hw/rtl/tri_pkg.sv =====
// Shared types and constants for the TSDF ray integrator.
`timescale 1ns / 1ps
package tri_pkg;

  localparam logic MODE_INTEGRATE = 1'b0;
  localparam logic MODE_READ      = 1'b1;

  localparam logic REG_CELL_SIZE  = 1'b0;
  localparam logic REG_TRUNCATION = 1'b1;

  localparam logic [9:0]  CELL_SIZE_RESET  = 10'd50;
  localparam logic [13:0] TRUNCATION_RESET = 14'd150;

  localparam logic signed [15:0] TSDF_ONE   = 16'sd16384;
  localparam logic signed [15:0] TSDF_MIN   = -16'sd16384;
  localparam logic [15:0]        WEIGHT_MAX = 16'hFFFF;

  typedef struct packed {
    logic        mode;
    logic [9:0]  sensor_x;
    logic [9:0]  sensor_y;
    logic [9:0]  end_x;
    logic [9:0]  end_y;
    logic [15:0] range_mm;
    logic [9:0]  query_x;
    logic [9:0]  query_y;
  } tri_in_t;

  typedef struct packed {
    logic [10:0]        cells_updated;
    logic signed [15:0] read_tsdf;
    logic [15:0]        read_weight;
  } tri_out_t;

  typedef struct packed {
    logic [9:0]  cell_size_mm;
    logic [13:0] truncation_mm;
  } tri_cfg_t;

  typedef enum logic [1:0] {
    JOB_CELL = 2'd0,
    JOB_END  = 2'd1,
    JOB_READ = 2'd2
  } tri_kind_t;

  typedef struct packed {
    tri_kind_t   kind;
    logic        on_map;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  adx;
    logic [9:0]  ady;
    logic [15:0] range_mm;
    logic [10:0] count;
  } tri_job_t;

endpackage

// ===== hw/rtl/tri_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1048576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tri_fifo.sv =====
// Small register queue used between the front and back ends and on the result side.
`timescale 1ns / 1ps
module tri_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/tri_front.sv =====
// Front end: takes items, walks the ray line and issues one job per on-map cell and an end job, or one read job.
`timescale 1ns / 1ps
module tri_front import tri_pkg::*; #(
  parameter int MAP_SIDE = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  tri_in_t  item,
  input  logic     take,
  output logic     ready,
  output tri_job_t job,
  output logic     job_push,
  input  logic     job_full
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_READ  = 4'b0010,
    F_SETUP = 4'b0100,
    F_WALK  = 4'b1000
  } front_state_t;

  front_state_t       state;
  tri_in_t            itm;
  logic               steep;
  logic [9:0]         a;
  logic [9:0]         a_last;
  logic [9:0]         b;
  logic [9:0]         da;
  logic [9:0]         db;
  logic               step_neg;
  logic signed [11:0] err;
  logic [10:0]        count;

  // Set-up values
  logic [9:0] adx, ady, s_a0, s_b0, s_a1, s_b1, u_a0, u_b0, u_a1, u_b1;
  logic       s_steep;
  // Walk values
  logic [9:0]         cx, cy;
  logic               cell_on_map;
  logic               query_on_map;
  logic signed [11:0] err_add;
  logic               do_step;
  logic               at_end;
  logic               advance;

  assign ready = (state == F_IDLE);

  always_comb begin
    adx     = (itm.end_x > itm.sensor_x) ? itm.end_x - itm.sensor_x : itm.sensor_x - itm.end_x;
    ady     = (itm.end_y > itm.sensor_y) ? itm.end_y - itm.sensor_y : itm.sensor_y - itm.end_y;
    s_steep = ady > adx;
    u_a0    = s_steep ? itm.sensor_y : itm.sensor_x;
    u_b0    = s_steep ? itm.sensor_x : itm.sensor_y;
    u_a1    = s_steep ? itm.end_y : itm.end_x;
    u_b1    = s_steep ? itm.end_x : itm.end_y;
    if (u_a0 > u_a1) begin
      s_a0 = u_a1;
      s_b0 = u_b1;
      s_a1 = u_a0;
      s_b1 = u_b0;
    end else begin
      s_a0 = u_a0;
      s_b0 = u_b0;
      s_a1 = u_a1;
      s_b1 = u_b1;
    end
  end

  always_comb begin
    cx           = steep ? b : a;
    cy           = steep ? a : b;
    cell_on_map  = (32'(cx) < MAP_SIDE) && (32'(cy) < MAP_SIDE);
    query_on_map = (32'(itm.query_x) < MAP_SIDE) && (32'(itm.query_y) < MAP_SIDE);
    err_add      = err + $signed({2'b00, db});
    do_step      = $signed({err_add, 1'b0}) >= $signed({3'b000, da});
    at_end       = (a == a_last);
    advance      = (state == F_WALK) && !at_end && (!cell_on_map || !job_full);
  end

  always_comb begin
    job          = '0;
    job.range_mm = itm.range_mm;
    job_push     = 1'b0;
    case (state)
      F_READ: begin
        job.kind   = JOB_READ;
        job.x      = itm.query_x;
        job.y      = itm.query_y;
        job.on_map = query_on_map;
        job_push   = !job_full;
      end
      F_WALK: begin
        job.x      = cx;
        job.y      = cy;
        job.adx    = (cx > itm.sensor_x) ? cx - itm.sensor_x : itm.sensor_x - cx;
        job.ady    = (cy > itm.sensor_y) ? cy - itm.sensor_y : itm.sensor_y - cy;
        job.count  = count;
        job.on_map = cell_on_map;
        if (at_end) begin
          job.kind = JOB_END;
          job_push = !job_full;
        end else begin
          job.kind = JOB_CELL;
          job_push = cell_on_map && !job_full;
        end
      end
      default: begin
        job_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      itm <= item;
    end
    if (state == F_SETUP) begin
      steep    <= s_steep;
      a        <= s_a0;
      a_last   <= s_a1;
      b        <= s_b0;
      da       <= s_a1 - s_a0;
      db       <= (s_b1 > s_b0) ? s_b1 - s_b0 : s_b0 - s_b1;
      step_neg <= !(s_b0 < s_b1);
      err      <= '0;
    end else if (advance) begin
      a <= a + 10'd1;
      if (do_step) begin
        b   <= step_neg ? b - 10'd1 : b + 10'd1;
        err <= err_add - $signed({2'b00, da});
      end else begin
        err <= err_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (take) begin
            state <= (item.mode == MODE_READ) ? F_READ : F_SETUP;
          end
        end
        F_READ: begin
          if (!job_full) begin
            state <= F_IDLE;
          end
        end
        F_SETUP: begin
          count <= '0;
          state <= F_WALK;
        end
        F_WALK: begin
          if (at_end) begin
            if (!job_full) begin
              state <= F_IDLE;
            end
          end else if (advance && cell_on_map) begin
            count <= count + 11'd1;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/tri_back.sv =====
// Back end: clears the map after reset, folds each cell job into the store and answers read and end jobs.
`timescale 1ns / 1ps
module tri_back import tri_pkg::*; #(
  parameter int MAP_SIDE = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  tri_cfg_t cfg,
  input  tri_job_t job,
  input  logic     job_empty,
  output logic     job_pop,
  output tri_out_t res,
  output logic     res_push,
  input  logic     res_full,
  output logic     clearing
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [12:0] {
    B_CLEAR = 13'b0000000000001,
    B_IDLE  = 13'b0000000000010,
    B_RD    = 13'b0000000000100,
    B_SQ    = 13'b0000000001000,
    B_MUL   = 13'b0000000010000,
    B_SQRT  = 13'b0000000100000,
    B_SUB   = 13'b0000001000000,
    B_DIV   = 13'b0000010000000,
    B_T     = 13'b0000100000000,
    B_PROD  = 13'b0001000000000,
    B_SUM   = 13'b0010000000000,
    B_FIN   = 13'b0100000000000,
    B_OUT   = 13'b1000000000000
  } back_state_t;

  back_state_t        state;
  tri_job_t           jb;
  logic [AW-1:0]      addr;
  logic [AW-1:0]      clr_addr;
  logic signed [15:0] old_t;
  logic [15:0]        old_w;
  logic [20:0]        sum_sq;
  logic [19:0]        cs2;
  logic [41:0]        sq_v;
  logic [41:0]        sq_r;
  logic [41:0]        sq_bit;
  logic [20:0]        dist_mm;
  logic               neg;
  logic signed [15:0] t;
  logic signed [32:0] prod;
  logic [17:0]        div_rem;
  logic [14:0]        div_lo;
  logic [14:0]        div_q;
  logic [16:0]        div_d;
  logic [3:0]         div_cnt;
  logic               div_second;

  logic [AW-1:0]      job_addr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        ram_wdata;
  logic               ram_re;
  logic [31:0]        ram_rdata;
  logic [40:0]        mprod;
  logic [41:0]        sq_sum;
  logic signed [22:0] n;
  logic [22:0]        n_mag;
  logic [13:0]        trunc_eff;
  logic signed [32:0] num;
  logic [32:0]        num_mag;
  logic [17:0]        div_tmp;
  logic               div_ge;
  logic [15:0]        q16;
  logic [15:0]        avg;
  logic [15:0]        w_next;

  assign clearing = (state == B_CLEAR);
  assign job_addr = AW'(32'(job.x) * MAP_SIDE + 32'(job.y));
  assign job_pop  = (state == B_IDLE) && !job_empty;
  assign res_push = (state == B_OUT) && !res_full;

  always_comb begin
    mprod     = 41'(sum_sq) * 41'(cs2);
    sq_sum    = sq_r + sq_bit;
    n         = $signed({7'b0, jb.range_mm}) - $signed({2'b00, dist_mm});
    n_mag     = n[22] ? 23'(-n) : 23'(n);
    trunc_eff = (cfg.truncation_mm == '0) ? 14'd1 : cfg.truncation_mm;
    num       = prod + 33'(t);
    num_mag   = num[32] ? 33'(-num) : 33'(num);
    div_tmp   = {div_rem[16:0], div_lo[14]};
    div_ge    = div_tmp >= {1'b0, div_d};
    q16       = {1'b0, div_q};
    avg       = neg ? 16'd0 - q16 : q16;
    w_next    = (old_w == WEIGHT_MAX) ? old_w : old_w + 16'd1;
  end

  // The store keeps the value in the upper half and the weight in the lower half.
  always_comb begin
    ram_re    = job_pop;
    ram_we    = (state == B_CLEAR) || (state == B_FIN);
    ram_waddr = (state == B_CLEAR) ? clr_addr : addr;
    ram_wdata = (state == B_CLEAR) ? {TSDF_MIN, 16'd0} : {avg, w_next};
  end

  tri_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(job_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        jb   <= job;
        addr <= job_addr;
        case (job.kind)
          JOB_END: res <= '{cells_updated: job.count, read_tsdf: '0, read_weight: '0};
          default: res <= '{cells_updated: '0, read_tsdf: TSDF_MIN, read_weight: '0};
        endcase
      end
      B_RD: begin
        res <= '{cells_updated: '0, read_tsdf: $signed(ram_rdata[31:16]),
                 read_weight: ram_rdata[15:0]};
      end
      B_SQ: begin
        old_t  <= $signed(ram_rdata[31:16]);
        old_w  <= ram_rdata[15:0];
        sum_sq <= 21'(jb.adx) * 21'(jb.adx) + 21'(jb.ady) * 21'(jb.ady);
        cs2    <= 20'(cfg.cell_size_mm) * 20'(cfg.cell_size_mm);
      end
      B_MUL: begin
        sq_v   <= {1'b0, mprod};
        sq_r   <= '0;
        sq_bit <= 42'd1 << 40;
      end
      B_SQRT: begin
        if (sq_bit == '0) begin
          dist_mm <= sq_r[20:0];
        end else begin
          if (sq_v >= sq_sum) begin
            sq_v <= sq_v - sq_sum;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
      end
      B_SUB: begin
        neg <= n[22];
        if (n_mag >= {9'b0, trunc_eff}) begin
          t <= n[22] ? TSDF_MIN : TSDF_ONE;
        end else begin
          // Quotient of |n| * 2^14 by the truncation stays below 2^14.
          div_rem    <= {5'b0, n_mag[13:1]};
          div_lo     <= {n_mag[0], 14'b0};
          div_d      <= {3'b0, trunc_eff};
          div_cnt    <= 4'd14;
          div_second <= 1'b0;
        end
      end
      B_DIV: begin
        div_rem <= div_ge ? div_tmp - {1'b0, div_d} : div_tmp;
        div_lo  <= div_lo << 1;
        div_q   <= {div_q[13:0], div_ge};
        div_cnt <= div_cnt - 4'd1;
      end
      B_T: begin
        t <= avg;
      end
      B_PROD: begin
        prod <= $signed({1'b0, old_w}) * old_t;
      end
      B_SUM: begin
        neg        <= num[32];
        div_rem    <= {1'b0, num_mag[31:15]};
        div_lo     <= num_mag[14:0];
        div_d      <= {1'b0, old_w} + 17'd1;
        div_cnt    <= 4'd14;
        div_second <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!job_empty) begin
            case (job.kind)
              JOB_CELL: state <= B_SQ;
              JOB_END:  state <= B_OUT;
              JOB_READ: state <= job.on_map ? B_RD : B_OUT;
              default:  state <= B_IDLE;
            endcase
          end
        end
        B_RD:   state <= B_OUT;
        B_SQ:   state <= B_MUL;
        B_MUL:  state <= B_SQRT;
        B_SQRT: begin
          if (sq_bit == '0) begin
            state <= B_SUB;
          end
        end
        B_SUB: begin
          state <= (n_mag >= {9'b0, trunc_eff}) ? B_PROD : B_DIV;
        end
        B_DIV: begin
          if (div_cnt == '0) begin
            state <= div_second ? B_FIN : B_T;
          end
        end
        B_T:    state <= B_PROD;
        B_PROD: state <= B_SUM;
        B_SUM:  state <= B_DIV;
        B_FIN:  state <= B_IDLE;
        B_OUT: begin
          if (!res_full) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tsdf_ray_integrator.sv =====
// Top level of the TSDF ray integrator: register port, front end, job queue, back end.
//
//   channel   handshake          payload    notes
//   input     push / full        item       integrate ray or read cell
//   result    pop / empty        result     one beat per input beat
//   config    psel/penable/...   pwdata     cell size at 0x0, truncation at 0x4
//
// A read job only reads the store and hands the value on to the result; an integrate job
// for a cell that lies on the map runs through the square root (21 steps) and up to two
// 15-step divisions that share one divider.
// After reset the back end writes every map cell once, with full held high;
// configuration writes are taken during that pass.
// The front end walks the next ray while the back end still works through the job queue.
`timescale 1ns / 1ps
module tsdf_ray_integrator import tri_pkg::*; #(
  parameter int MAP_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  tri_in_t     item,
  input  logic        pop,
  output logic        empty,
  output tri_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0]  cell_size_mm;
  logic [13:0] truncation_mm;
  tri_cfg_t    cfg;
  logic        cfg_write;
  logic        take;
  logic        front_ready;
  logic        clearing;
  tri_job_t    fj;
  logic        fj_push;
  logic        jq_full;
  tri_job_t    jq_data;
  logic        jq_empty;
  logic        jq_pop;
  tri_out_t    bres;
  logic        bres_push;
  logic        rq_full;
  logic [$bits(tri_out_t)-1:0] rq_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg       = '{cell_size_mm: cell_size_mm, truncation_mm: truncation_mm};

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size_mm  <= CELL_SIZE_RESET;
      truncation_mm <= TRUNCATION_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_CELL_SIZE:  cell_size_mm  <= pwdata[9:0];
        REG_TRUNCATION: truncation_mm <= pwdata[13:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CELL_SIZE:  prdata = {22'b0, cell_size_mm};
      REG_TRUNCATION: prdata = {18'b0, truncation_mm};
      default:        prdata = '0;
    endcase
  end

  assign full = !front_ready || clearing;
  assign take = push && !full;

  tri_front #(
    .MAP_SIDE(MAP_SIDE)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .take    (take),
    .ready   (front_ready),
    .job     (fj),
    .job_push(fj_push),
    .job_full(jq_full)
  );

  tri_fifo #(
    .WIDTH($bits(tri_job_t)),
    .DEPTH(4)
  ) u_job_q (
    .clk    (clk),
    .rst    (rst),
    .push   (fj_push),
    .wr_data(fj),
    .full   (jq_full),
    .pop    (jq_pop),
    .rd_data(jq_data),
    .empty  (jq_empty)
  );

  tri_back #(
    .MAP_SIDE(MAP_SIDE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job      (jq_data),
    .job_empty(jq_empty),
    .job_pop  (jq_pop),
    .res      (bres),
    .res_push (bres_push),
    .res_full (rq_full),
    .clearing (clearing)
  );

  tri_fifo #(
    .WIDTH($bits(tri_out_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .push   (bres_push),
    .wr_data(bres),
    .full   (rq_full),
    .pop    (pop),
    .rd_data(rq_data),
    .empty  (empty)
  );

  assign result = tri_out_t'(rq_data);

endmodule

// ===== hw/rtl/tri_checker.sv =====
// Port-level checks for the TSDF ray integrator, bound to the top level.
`timescale 1ns / 1ps
module tri_checker import tri_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     push,
  input logic     full,
  input logic     pop,
  input logic     empty,
  input tri_out_t result
);

  // The map clearing pass keeps the input closed straight after reset.
  a_full_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A ray beat carries only a count, a read beat never carries one.
  a_ray_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.cells_updated != 11'd0) |->
      (result.read_tsdf == 16'sd0 && result.read_weight == 16'd0))
    else $error("ray result with read fields set");

  a_tsdf_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.read_tsdf >= TSDF_MIN && result.read_tsdf <= TSDF_ONE))
    else $error("stored value outside plus or minus one");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind tsdf_ray_integrator tri_checker u_tri_checker (
  .clk   (clk),
  .rst   (rst),
  .push  (push),
  .full  (full),
  .pop   (pop),
  .empty (empty),
  .result(result)
);
